@@ rtl/serpentine_raster_scan_core_macros.svh @@
// Assertion macros for the serpentine raster scan core.
// Taken in by the RTL files that carry concurrent checks; depends on nothing.
`ifndef SERPENTINE_RASTER_SCAN_CORE_MACROS_SVH
`define SERPENTINE_RASTER_SCAN_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("serpentine raster scan check failed");
`define SRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("serpentine raster scan invariant failed");
`else
`define SRS_ASSERT(lbl, clk, rst, prop)
`define SRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/srs_pkg.sv @@
// Shared types, constants and helper functions of the serpentine raster scan core.
// Depends on nothing; the core, srs_out_if, srs_digits and srs_coord refer to it by scoped names.
package srs_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 16;

  localparam int CNT_W      = 9;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int DIGIT_W    = $clog2(MAX_POINTS);
  localparam int PT_W       = (CNT_W > DIGIT_W) ? CNT_W : DIGIT_W + 1;
  localparam int PROD_W     = COORD_BITS + DIGIT_W + 1;
  localparam int SUM_W      = PROD_W + 1;
  localparam int WIDE_W     = CFG_DATA_W + 3 * COORD_BITS;

  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_X = 3'd0,
    REG_POINTS_Y = 3'd1,
    REG_POINTS_Z = 3'd2,
    REG_START    = 3'd3,
    REG_STEP     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    count_t px;
    count_t py;
    count_t pz;
  } counts_t;

  // Scan point after clamping and mirroring, plus the status seen at request time.
  typedef struct packed {
    digit_t dx;
    digit_t dy;
    digit_t dz;
    logic   more;
  } point_t;

  // Index of the last point on an axis; a count of zero acts as one.
  function automatic digit_t last_of(count_t p);
    logic [PT_W-1:0] pw;
    pw = PT_W'(p);
    if (pw == '0) begin
      return '0;
    end else if (pw > PT_W'(MAX_POINTS)) begin
      return digit_t'(MAX_POINTS - 1);
    end else begin
      return digit_t'(pw - PT_W'(1));
    end
  endfunction

  function automatic coord_t field_of(logic [CFG_DATA_W-1:0] packed_val, int axis);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(packed_val);
    return wide[axis*COORD_BITS +: COORD_BITS];
  endfunction

endpackage

@@ rtl/srs_in_if.sv @@
// Request channel of the serpentine raster scan core: valid/ready plus the advance flag.
// Depends on nothing.
interface srs_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

@@ rtl/srs_out_if.sv @@
// Result channel of the serpentine raster scan core: valid/ready plus the point fields.
// Depends on srs_pkg for the coordinate width.
interface srs_out_if;
  logic               valid;
  logic               ready;
  srs_pkg::coord_t    pos_x;
  srs_pkg::coord_t    pos_y;
  srs_pkg::coord_t    pos_z;
  logic               more_points;
  logic               clipped;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output more_points, output clipped, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input more_points, input clipped, output ready);
endinterface

@@ rtl/serpentine_raster_scan_core.sv @@
// Serpentine raster scan core: configuration registers, request and result stages.
// Depends on srs_pkg, srs_in_if, srs_out_if, srs_digits, srs_coord and the macro header.
//
//   channel   dir  handshake      payload
//   req_ch    in   valid/ready    advance
//   res_ch    out  valid/ready    pos_x, pos_y, pos_z, more_points, clipped
//   cfg       in   cfg_wr_en      cfg_index, cfg_data (no read-back)
//
// One request per cycle is taken unless a stalled result has filled both stages; its
// result passes through the first stage and then the second, which drives res_ch.
// The first stage registers the mirrored digits, the second holds the three
// multiply-add-saturate results.
// A stalled result holds both stages; ready falls only when both are full.
// Synchronous reset restores unit point counts, zero start and step, and the first point.
`include "serpentine_raster_scan_core_macros.svh"

module serpentine_raster_scan_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data,
  srs_in_if.sink                           req_ch,
  srs_out_if.source                        res_ch
);

  srs_pkg::counts_t                 counts;
  logic [srs_pkg::CFG_DATA_W-1:0]   start_packed;
  logic [srs_pkg::CFG_DATA_W-1:0]   step_packed;

  srs_pkg::point_t pt_now;
  srs_pkg::point_t s1_pt;
  logic            s1_valid;
  logic            s1_move;
  logic            accept;

  srs_pkg::coord_t pos_x_c, pos_y_c, pos_z_c;
  logic            clip_x, clip_y, clip_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.px    <= srs_pkg::count_t'(1);
      counts.py    <= srs_pkg::count_t'(1);
      counts.pz    <= srs_pkg::count_t'(1);
      start_packed <= '0;
      step_packed  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        srs_pkg::REG_POINTS_X: counts.px    <= cfg_data[srs_pkg::CNT_W-1:0];
        srs_pkg::REG_POINTS_Y: counts.py    <= cfg_data[srs_pkg::CNT_W-1:0];
        srs_pkg::REG_POINTS_Z: counts.pz    <= cfg_data[srs_pkg::CNT_W-1:0];
        srs_pkg::REG_START:    start_packed <= cfg_data;
        srs_pkg::REG_STEP:     step_packed  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_move      = !res_ch.valid || res_ch.ready;
  assign req_ch.ready = !s1_valid || s1_move;
  assign accept       = req_ch.valid && req_ch.ready;

  // The point is reported from the digits as they stand, then the counters step.
  srs_digits u_digits (
    .clk     (clk),
    .rst     (rst),
    .step_en (accept && req_ch.advance),
    .counts  (counts),
    .pt      (pt_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pt <= pt_now;
    end
  end

  srs_coord u_coord_x (
    .start (srs_pkg::field_of(start_packed, 0)),
    .step  (srs_pkg::field_of(step_packed, 0)),
    .digit (s1_pt.dx),
    .pos   (pos_x_c),
    .clip  (clip_x)
  );

  srs_coord u_coord_y (
    .start (srs_pkg::field_of(start_packed, 1)),
    .step  (srs_pkg::field_of(step_packed, 1)),
    .digit (s1_pt.dy),
    .pos   (pos_y_c),
    .clip  (clip_y)
  );

  srs_coord u_coord_z (
    .start (srs_pkg::field_of(start_packed, 2)),
    .step  (srs_pkg::field_of(step_packed, 2)),
    .digit (s1_pt.dz),
    .pos   (pos_z_c),
    .clip  (clip_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (s1_move) begin
      res_ch.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      res_ch.pos_x       <= pos_x_c;
      res_ch.pos_y       <= pos_y_c;
      res_ch.pos_z       <= pos_z_c;
      res_ch.more_points <= s1_pt.more;
      res_ch.clipped     <= clip_x || clip_y || clip_z;
    end
  end

  `SRS_ASSERT(a_accept_fills, clk, rst, accept |=> s1_valid)
  `SRS_ASSERT(a_stage_feeds_out, clk, rst, (s1_valid && s1_move) |=> res_ch.valid)
  `SRS_ASSERT(a_drain_empties, clk, rst, (res_ch.valid && res_ch.ready && !s1_valid) |=> !res_ch.valid)

endmodule

@@ rtl/srs_digits.sv @@
// Mixed-radix digit counters of the scan and the serpentine mirroring of the current point.
// Depends on srs_pkg and the assertion macro header.
`include "serpentine_raster_scan_core_macros.svh"

module srs_digits (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  srs_pkg::counts_t counts,
  output srs_pkg::point_t  pt
);

  srs_pkg::digit_t last_x, last_y, last_z;
  srs_pkg::digit_t x_digit, y_digit, z_digit;
  srs_pkg::digit_t x_digit_next, y_digit_next, z_digit_next;
  srs_pkg::digit_t dx_c, dy_c, dz_c, dy_m;
  logic            scan_done, scan_done_next;
  logic            carry_x, carry_y, carry_z;
  logic            wrap_all;

  assign last_x = srs_pkg::last_of(counts.px);
  assign last_y = srs_pkg::last_of(counts.py);
  assign last_z = srs_pkg::last_of(counts.pz);

  // A digit left beyond a shrunken count reads as the last point.
  assign dx_c = (x_digit > last_x) ? last_x : x_digit;
  assign dy_c = (y_digit > last_y) ? last_y : y_digit;
  assign dz_c = (z_digit > last_z) ? last_z : z_digit;

  assign dy_m = dz_c[0] ? (last_y - dy_c) : dy_c;

  always_comb begin
    pt.dz   = dz_c;
    pt.dy   = dy_m;
    pt.dx   = dy_m[0] ? (last_x - dx_c) : dx_c;
    pt.more = !scan_done;
  end

  assign carry_x  = (x_digit >= last_x);
  assign carry_y  = (y_digit >= last_y);
  assign carry_z  = (z_digit >= last_z);
  assign wrap_all = step_en && carry_x && carry_y && carry_z;

  always_comb begin
    x_digit_next   = x_digit;
    y_digit_next   = y_digit;
    z_digit_next   = z_digit;
    scan_done_next = scan_done;
    if (step_en) begin
      x_digit_next = carry_x ? '0 : x_digit + 1'b1;
      if (carry_x) begin
        y_digit_next = carry_y ? '0 : y_digit + 1'b1;
        if (carry_y) begin
          z_digit_next = carry_z ? '0 : z_digit + 1'b1;
          if (carry_z) begin
            scan_done_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_digit   <= '0;
      y_digit   <= '0;
      z_digit   <= '0;
      scan_done <= 1'b0;
    end else begin
      x_digit   <= x_digit_next;
      y_digit   <= y_digit_next;
      z_digit   <= z_digit_next;
      scan_done <= scan_done_next;
    end
  end

  `SRS_ASSERT(a_done_sticky, clk, rst, scan_done |=> scan_done)
  `SRS_ASSERT(a_wrap_sets_done, clk, rst, wrap_all |=> (scan_done && x_digit == '0))
  `SRS_ASSERT(a_point_in_range, clk, rst, (pt.dx <= last_x) && (pt.dy <= last_y))

endmodule

@@ rtl/srs_coord.sv @@
// One axis of the coordinate datapath: start plus signed step times digit, saturated.
// Depends on srs_pkg.
module srs_coord (
  input  srs_pkg::coord_t start,
  input  srs_pkg::coord_t step,
  input  srs_pkg::digit_t digit,
  output srs_pkg::coord_t pos,
  output logic            clip
);

  logic signed [srs_pkg::COORD_BITS-1:0] step_s;
  logic signed [srs_pkg::DIGIT_W:0]      digit_s;
  logic signed [srs_pkg::PROD_W-1:0]     prod;
  logic signed [srs_pkg::SUM_W-1:0]      sum;

  assign step_s  = step;
  assign digit_s = {1'b0, digit};
  assign prod    = step_s * digit_s;
  assign sum     = $signed({{(srs_pkg::SUM_W - srs_pkg::COORD_BITS){1'b0}}, start})
                 + $signed({prod[srs_pkg::PROD_W-1], prod});

  always_comb begin
    if (sum[srs_pkg::SUM_W-1]) begin
      pos  = '0;
      clip = 1'b1;
    end else if (|sum[srs_pkg::SUM_W-2:srs_pkg::COORD_BITS]) begin
      pos  = '1;
      clip = 1'b1;
    end else begin
      pos  = sum[srs_pkg::COORD_BITS-1:0];
      clip = 1'b0;
    end
  end

endmodule

@@ tb/serpentine_raster_scan_core_tb.sv @@
// Self-checking testbench for the serpentine raster scan core: directed and random requests,
// checked against a predictor of the scan order, mirroring and saturated coordinates.
// Depends on srs_pkg, srs_in_if, srs_out_if and serpentine_raster_scan_core.
`timescale 1ns / 100ps

module serpentine_raster_scan_core_tb;
  import srs_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   more;
    logic   clip;
  } scan_point_t;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srs_in_if req_ch();
  srs_out_if res_ch();

  serpentine_raster_scan_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_ch(req_ch),
    .res_ch(res_ch)
  );

  // Predictor copy of the registers and the scan position.
  logic [CNT_W-1:0] cnt_x = 1, cnt_y = 1, cnt_z = 1;
  logic [CFG_DATA_W-1:0] start_pos = '0, step_size = '0;
  int unsigned scan_x = 0, scan_y = 0, scan_z = 0;
  bit scan_wrapped = 0;

  bit pending_advance[$];
  scan_point_t expected_points[$];
  int error_count = 0;
  int grants = 0;
  int grants_seen = 0;
  int req_gap = 0;
  int res_stall = 0;
  bit calm = 0;
  bit long_hold_req = 0;
  bit long_hold_done = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned span(logic [CNT_W-1:0] p);
    if (p == 0) return 1;
    if (p > MAX_POINTS) return MAX_POINTS;
    return p;
  endfunction

  function automatic int axis_raw(int axis, int unsigned d);
    return int'(start_pos[axis*COORD_BITS +: COORD_BITS])
         + int'($signed(step_size[axis*COORD_BITS +: COORD_BITS])) * int'(d);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return coord_t'(v);
  endfunction

  function automatic scan_point_t predict_point();
    int unsigned nx, ny, nz, dx, dy, dz;
    int raw [3];
    scan_point_t pt;
    nx = span(cnt_x);
    ny = span(cnt_y);
    nz = span(cnt_z);
    // Digits left beyond a shrunken axis report as its last point.
    dx = (scan_x > nx - 1) ? nx - 1 : scan_x;
    dy = (scan_y > ny - 1) ? ny - 1 : scan_y;
    dz = (scan_z > nz - 1) ? nz - 1 : scan_z;
    if (dz % 2 == 1) dy = ny - 1 - dy;
    if (dy % 2 == 1) dx = nx - 1 - dx;
    raw[0] = axis_raw(0, dx);
    raw[1] = axis_raw(1, dy);
    raw[2] = axis_raw(2, dz);
    pt.x = clamp_coord(raw[0]);
    pt.y = clamp_coord(raw[1]);
    pt.z = clamp_coord(raw[2]);
    pt.more = !scan_wrapped;
    pt.clip = 0;
    for (int a = 0; a < 3; a++) begin
      if (raw[a] < 0 || raw[a] > COORD_MAX) pt.clip = 1;
    end
    return pt;
  endfunction

  function automatic void step_scan();
    if (scan_x >= span(cnt_x) - 1) begin
      scan_x = 0;
      if (scan_y >= span(cnt_y) - 1) begin
        scan_y = 0;
        if (scan_z >= span(cnt_z) - 1) begin
          scan_z = 0;
          scan_wrapped = 1;
        end else begin
          scan_z++;
        end
      end else begin
        scan_y++;
      end
    end else begin
      scan_x++;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : scan_checker
    scan_point_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("result %h,%h,%h with no request outstanding",
                                    res_ch.pos_x, res_ch.pos_y, res_ch.pos_z));
        end else begin
          want = expected_points.pop_front();
          check_field("pos_x", res_ch.pos_x, want.x);
          check_field("pos_y", res_ch.pos_y, want.y);
          check_field("pos_z", res_ch.pos_z, want.z);
          check_field("more_points", res_ch.more_points, want.more);
          check_field("clipped", res_ch.clipped, want.clip);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_points.push_back(predict_point());
        if (req_ch.advance) step_scan();
        pending_advance.delete(0);
        grants++;
      end
    end
  end

  always @(negedge clk) begin : req_driver
    logic nxt_valid;
    logic nxt_adv;
    nxt_valid = 0;
    nxt_adv = req_ch.advance;
    if (!rst) begin
      if (grants != grants_seen) begin
        grants_seen = grants;
        if (!calm && $urandom_range(0, 4) == 0) req_gap = $urandom_range(1, 8);
      end
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_advance.size() > 0) begin
        nxt_valid = 1;
        nxt_adv = pending_advance[0];
      end
    end
    req_ch.valid <= nxt_valid;
    req_ch.advance <= nxt_adv;
  end

  always @(negedge clk) begin : res_sink
    logic nxt_ready;
    nxt_ready = 1;
    if (!rst) begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1;
        res_stall = HOLD_CYCLES;
      end else if (res_stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        res_stall = $urandom_range(1, 8);
      end
      if (res_stall > 0) begin
        res_stall--;
        nxt_ready = 0;
      end
    end
    res_ch.ready <= nxt_ready;
  end

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return '1;
      3: return CNT_W'(MAX_POINTS);
      4: return CNT_W'(MAX_POINTS + 1);
      default: return CNT_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic coord_t pick_start();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_step();
    case ($urandom_range(0, 4))
      0: return coord_t'(1 << (COORD_BITS - 1));
      1: return coord_t'(COORD_MAX >> 1);
      2: return '0;
      3: return coord_t'($urandom_range(0, 1023)) - coord_t'(512);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_POINTS_X: cnt_x = data[CNT_W-1:0];
      REG_POINTS_Y: cnt_y = data[CNT_W-1:0];
      REG_POINTS_Z: cnt_z = data[CNT_W-1:0];
      REG_START:    start_pos = data;
      REG_STEP:     step_size = data;
      default: ;
    endcase
  endtask

  // Upper bits of a count write carry noise that the register must drop.
  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] c);
    logic [CFG_DATA_W-1:0] w;
    w = rand_word();
    w[CNT_W-1:0] = c;
    write_reg(idx, w);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic feed(int n, int adv_pct);
    for (int i = 0; i < n; i++) begin
      pending_advance.push_back($urandom_range(0, 99) < adv_pct);
    end
  endtask

  task automatic drain();
    while (pending_advance.size() != 0 || expected_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] cx, cy, cz;
    rst = 1;
    cfg_wr_en = 0;
    cfg_index = REG_POINTS_X;
    cfg_data = '0;
    req_ch.valid = 0;
    req_ch.advance = 0;
    res_ch.ready = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Reset configuration: a single point at the origin, reported twice.
    pending_advance.push_back(1'b0);
    pending_advance.push_back(1'b0);
    drain();

    // Small grid walked through two z layers to show both kinds of mirroring.
    write_count(REG_POINTS_X, 3);
    write_count(REG_POINTS_Y, 2);
    write_count(REG_POINTS_Z, CNT_W'(MAX_POINTS + 1));
    write_reg(REG_START, {16'h0000, 16'hFFFF, 16'h8000});
    write_reg(REG_STEP, {16'h7FFF, 16'h8000, 16'h0001});
    end_writes();
    repeat (12) pending_advance.push_back(1'b1);
    drain();

    // Zero x count, saturated y count, z shrunk below its digit; clip high.
    for (int i = int'(REG_STEP) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), rand_word());
    end
    write_count(REG_POINTS_X, 0);
    write_count(REG_POINTS_Y, '1);
    write_count(REG_POINTS_Z, 1);
    write_reg(REG_START, '1);
    write_reg(REG_STEP, {3{16'h7FFF}});
    end_writes();
    pending_advance.push_back(1'b0);
    pending_advance.push_back(1'b1);
    pending_advance.push_back(1'b1);
    drain();

    // Most negative steps from a zero start clip low.
    write_reg(REG_START, '0);
    write_reg(REG_STEP, {3{16'h8000}});
    end_writes();
    pending_advance.push_back(1'b1);
    pending_advance.push_back(1'b0);
    drain();

    // Early phases keep a deep z axis so the scan cannot finish; the tiny grid
    // of phase six forces the end of scan, after which anything goes.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6) begin
        cx = CNT_W'($urandom_range(2, 8));
        cy = CNT_W'($urandom_range(2, 8));
        cz = CNT_W'($urandom_range(MAX_POINTS, (1 << CNT_W) - 1));
      end else if (ph == 6) begin
        cx = CNT_W'($urandom_range(1, 2));
        cy = CNT_W'($urandom_range(1, 2));
        cz = CNT_W'($urandom_range(1, 2));
      end else begin
        cx = pick_count();
        cy = pick_count();
        cz = pick_count();
      end
      write_count(REG_POINTS_X, cx);
      write_count(REG_POINTS_Y, cy);
      write_count(REG_POINTS_Z, cz);
      write_reg(REG_START, {pick_start(), pick_start(), pick_start()});
      write_reg(REG_STEP, {pick_step(), pick_step(), pick_step()});
      end_writes();
      if (ph == 2) long_hold_req = 1;
      if (ph >= 10) calm = 1;
      feed($urandom_range(55, 85), (ph == 6) ? 90 : 50);
      drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
